### hdl/pta_pkg.sv
// ----------------------------------------------------------------------------
// pta_pkg
// shared types and constants of the priority token arbiter
// ----------------------------------------------------------------------------
package pta_pkg;

  localparam int TABLE_DEPTH = 512;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int HOST_W      = 16;
  localparam int SLOT_W      = 6;
  localparam int PRIO_W      = 8;
  localparam int TS_W        = 32;
  localparam int ACTION_W    = 2;
  localparam int KIND_W      = 3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_GET     = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_FAIL    = 2'd2
  } action_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_GRANT = 3'd0,
    KIND_WAIT  = 3'd1,
    KIND_FULL  = 3'd2,
    KIND_ACK   = 3'd3,
    KIND_GIVE  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FREE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE,
    ST_GIVE
  } state_e;

  typedef struct packed {
    logic                     valid;
    logic [HOST_W-1:0]        host;
    logic [SLOT_W-1:0]        slot;
    logic signed [PRIO_W-1:0] prio;
    logic signed [TS_W-1:0]   ts;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic fail;
    logic clr_wr;
    logic scan_rd;
    logic free_hold;
    logic commit;
    logic emit_give;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic holder_valid;
    logic sync;
    logic cnt_last;
    logic out_busy;
    logic give_pending;
  } sts_t;

endpackage

### hdl/pta_ifs.sv
// ----------------------------------------------------------------------------
// pta channel interfaces
// request, result and configuration channels with valid/ready
// ----------------------------------------------------------------------------
interface pta_in_if;
  logic                              valid;
  logic                              ready;
  logic [pta_pkg::ACTION_W-1:0]      action;
  logic [pta_pkg::HOST_W-1:0]        requester_host;
  logic [pta_pkg::SLOT_W-1:0]        client_slot;
  logic signed [pta_pkg::PRIO_W-1:0] priority_req;
  logic signed [pta_pkg::TS_W-1:0]   timestamp;

  modport source (output valid, action, requester_host, client_slot, priority_req,
                  timestamp, input ready);
  modport sink (input valid, action, requester_host, client_slot, priority_req,
                timestamp, output ready);
endinterface

interface pta_out_if;
  logic                         valid;
  logic                         ready;
  logic [pta_pkg::KIND_W-1:0]   kind;
  logic                         release_had_holder;
  logic [pta_pkg::HOST_W-1:0]   target_host;
  logic [pta_pkg::SLOT_W-1:0]   target_slot;
  logic                         last;

  modport source (output valid, kind, release_had_holder, target_host, target_slot,
                  last, input ready);
  modport sink (input valid, kind, release_had_holder, target_host, target_slot,
                last, output ready);
endinterface

interface pta_cfg_if;
  logic valid;
  logic ready;
  logic sync_complete;

  modport source (output valid, sync_complete, input ready);
  modport sink (input valid, sync_complete, output ready);
endinterface

### hdl/priority_token_arbiter_core.sv
// ----------------------------------------------------------------------------
// priority_token_arbiter_core
// one exclusive token handed among requests waiting in a 512-entry table
// ----------------------------------------------------------------------------
//  channel  dir  beat
//  req_i    in   action, requester_host, client_slot, priority_req, timestamp
//  rsp_o    out  kind, release_had_holder, target_host, target_slot, last
//  cfg_i    in   sync_complete
//
//  after reset a clearing pass over all 512 entries empties the table; no request
//  is taken meanwhile (cfg writes are)
//  get: one read per cycle over all 512 entries, one request at a time
//  release with holder and sync: frees the holder, rescans, then adds a give beat
//  release without holder, or delivery failure: no scan; a failure gives no beat
//  the wait table has a single read port, so a scan reads one entry at a time
//  a pending result beat stalls the commit until rsp_o drains
// ----------------------------------------------------------------------------
module priority_token_arbiter_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  pta_in_if.sink    req_i,
  pta_out_if.source rsp_o,
  pta_cfg_if.sink   cfg_i
);
  import pta_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // the register write always completes in the cycle it is offered
  assign cfg_i.ready = 1'b1;

  // sequencer: owns the request handshake
  pta_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_action_i (req_i.action),
    .in_ready_o  (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // table, scan trackers and the result register
  pta_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_action_i (req_i.action),
    .in_host_i   (req_i.requester_host),
    .in_slot_i   (req_i.client_slot),
    .in_prio_i   (req_i.priority_req),
    .in_ts_i     (req_i.timestamp),
    .cfg_we_i    (cfg_i.valid),
    .cfg_sync_i  (cfg_i.sync_complete),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .out_kind_o  (rsp_o.kind),
    .out_had_o   (rsp_o.release_had_holder),
    .out_host_o  (rsp_o.target_host),
    .out_slot_o  (rsp_o.target_slot),
    .out_last_o  (rsp_o.last)
  );

endmodule

### hdl/pta_ctrl.sv
// ----------------------------------------------------------------------------
// pta_ctrl
// sequencer: clearing pass, table scans, commit and result beats
// ----------------------------------------------------------------------------
module pta_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [pta_pkg::ACTION_W-1:0] in_action_i,
  output logic                         in_ready_o,
  input  pta_pkg::sts_t                sts_i,
  output pta_pkg::cmd_t                cmd_o
);
  import pta_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.cnt_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_action_i == ACT_GET) begin
            state_d = ST_SCAN;
          end else if (in_action_i == ACT_RELEASE) begin
            state_d = sts_i.holder_valid ? ST_FREE : ST_DONE;
          end
        end
      end
      ST_FREE:  state_d = sts_i.sync ? ST_SCAN : ST_DONE;
      ST_SCAN: begin
        if (sts_i.cnt_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_DONE;
      ST_DONE: begin
        if (!sts_i.out_busy) state_d = sts_i.give_pending ? ST_GIVE : ST_IDLE;
      end
      ST_GIVE: begin
        if (!sts_i.out_busy) state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clr_wr = 1'b1;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
        cmd_o.fail = in_valid_i && (in_action_i == ACT_FAIL);
      end
      ST_FREE:  cmd_o.free_hold = 1'b1;
      ST_SCAN:  cmd_o.scan_rd = 1'b1;
      ST_DRAIN: ;
      ST_DONE:  cmd_o.commit = !sts_i.out_busy;
      ST_GIVE:  cmd_o.emit_give = !sts_i.out_busy;
      default:  ;
    endcase
  end

endmodule

### hdl/pta_dp.sv
// ----------------------------------------------------------------------------
// pta_dp
// wait table memory, scan trackers, holder state and result register
// ----------------------------------------------------------------------------
module pta_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pta_pkg::cmd_t                      cmd_i,
  output pta_pkg::sts_t                      sts_o,
  input  logic [pta_pkg::ACTION_W-1:0]       in_action_i,
  input  logic [pta_pkg::HOST_W-1:0]         in_host_i,
  input  logic [pta_pkg::SLOT_W-1:0]         in_slot_i,
  input  logic signed [pta_pkg::PRIO_W-1:0]  in_prio_i,
  input  logic signed [pta_pkg::TS_W-1:0]    in_ts_i,
  input  logic                               cfg_we_i,
  input  logic                               cfg_sync_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [pta_pkg::KIND_W-1:0]         out_kind_o,
  output logic                               out_had_o,
  output logic [pta_pkg::HOST_W-1:0]         out_host_o,
  output logic [pta_pkg::SLOT_W-1:0]         out_slot_o,
  output logic                               out_last_o
);
  import pta_pkg::*;

  entry_t mem [TABLE_DEPTH];

  logic [IDX_W-1:0]        cnt_q;
  entry_t                  rd_data_q;
  logic [IDX_W-1:0]        rd_idx_q;
  logic                    rd_vld_q;
  logic                    sync_q;
  logic                    holder_valid_q;
  logic [IDX_W-1:0]        holder_idx_q;

  logic [ACTION_W-1:0]     op_q;
  logic                    had_q;
  logic [HOST_W-1:0]       host_q;
  logic [SLOT_W-1:0]       slot_q;
  logic signed [PRIO_W-1:0] prio_q;
  logic signed [TS_W-1:0]  ts_q;

  logic                    match_q, free_q, found_q;
  logic [IDX_W-1:0]        match_idx_q, free_idx_q, best_idx_q;
  logic signed [TS_W-1:0]  match_ts_q, best_t_q;
  logic signed [PRIO_W-1:0] best_p_q;
  logic [HOST_W-1:0]       best_host_q;
  logic [SLOT_W-1:0]       best_slot_q;

  logic                    out_valid_q, out_had_q, out_last_q;
  logic [KIND_W-1:0]       out_kind_q;
  logic [HOST_W-1:0]       out_host_q;
  logic [SLOT_W-1:0]       out_slot_q;

  logic                    we;
  logic [IDX_W-1:0]        wa;
  entry_t                  wd;
  logic                    is_get, is_hit, is_take;
  logic                    emit;
  logic [KIND_W-1:0]       emit_kind;
  logic                    emit_had, emit_last;
  logic [SLOT_W-1:0]       emit_slot;

  assign is_get = (op_q == ACT_GET);
  assign is_hit = rd_data_q.valid && (rd_data_q.host == host_q)
                  && (rd_data_q.slot == slot_q);
  // skip lower priority, or equal priority with later time; ties go to later index
  assign is_take = rd_data_q.valid
                   && !(rd_data_q.prio < best_p_q)
                   && !((rd_data_q.prio == best_p_q) && (rd_data_q.ts > best_t_q));

  assign sts_o.holder_valid = holder_valid_q;
  assign sts_o.sync         = sync_q;
  assign sts_o.cnt_last     = (cnt_q == IDX_W'(TABLE_DEPTH - 1));
  assign sts_o.out_busy     = out_valid_q;
  assign sts_o.give_pending = !is_get && had_q && sync_q && found_q;

  // memory write port and commit decode
  always_comb begin
    we        = 1'b0;
    wa        = cnt_q;
    wd        = '0;
    emit      = 1'b0;
    emit_kind = KIND_ACK;
    emit_had  = 1'b0;
    emit_last = 1'b1;
    emit_slot = '0;
    if (cmd_i.clr_wr) begin
      we = 1'b1;
    end else if (cmd_i.free_hold) begin
      we = 1'b1;
      wa = holder_idx_q;
    end else if (cmd_i.commit) begin
      emit = 1'b1;
      if (is_get) begin
        if (match_q) begin
          we        = 1'b1;
          wa        = match_idx_q;
          wd        = '{valid: 1'b1, host: host_q, slot: slot_q, prio: prio_q,
                        ts: match_ts_q};
          emit_kind = KIND_WAIT;
        end else if (free_q) begin
          we = 1'b1;
          wa = free_idx_q;
          wd = '{valid: 1'b1, host: host_q, slot: slot_q, prio: prio_q, ts: ts_q};
          if (holder_valid_q) begin
            emit_kind = KIND_WAIT;
          end else begin
            emit_kind = KIND_GRANT;
            emit_slot = slot_q;
          end
        end else begin
          emit_kind = KIND_FULL;
        end
      end else begin
        emit_had = had_q;
        if (had_q && sync_q && found_q) begin
          we        = 1'b1;
          wa        = best_idx_q;
          emit_last = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (cmd_i.scan_rd) rd_data_q <= mem[cnt_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q          <= '0;
      rd_vld_q       <= 1'b0;
      sync_q         <= 1'b0;
      holder_valid_q <= 1'b0;
      holder_idx_q   <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_rd;
      if (cmd_i.clr_wr || cmd_i.scan_rd) cnt_q <= cnt_q + 1'b1;
      if (cfg_we_i) sync_q <= cfg_sync_i;
      if (cmd_i.fail || cmd_i.free_hold) holder_valid_q <= 1'b0;
      if (cmd_i.commit) begin
        if (is_get && !match_q && free_q && !holder_valid_q) begin
          holder_valid_q <= 1'b1;
          holder_idx_q   <= free_idx_q;
        end else if (!is_get && had_q && sync_q && found_q) begin
          holder_valid_q <= 1'b1;
          holder_idx_q   <= best_idx_q;
        end
      end
      if (emit || cmd_i.emit_give) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request capture, scan trackers and result payload
  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q;
    if (cmd_i.load) begin
      op_q     <= in_action_i;
      had_q    <= holder_valid_q;
      host_q   <= in_host_i;
      slot_q   <= in_slot_i;
      prio_q   <= in_prio_i;
      ts_q     <= in_ts_i;
      match_q  <= 1'b0;
      free_q   <= 1'b0;
      found_q  <= 1'b0;
      best_p_q <= -8'sd1;
      best_t_q <= 32'sh7fffffff;
    end else if (rd_vld_q) begin
      if (!match_q && is_hit) begin
        match_q     <= 1'b1;
        match_idx_q <= rd_idx_q;
        match_ts_q  <= rd_data_q.ts;
      end
      if (!free_q && !rd_data_q.valid) begin
        free_q     <= 1'b1;
        free_idx_q <= rd_idx_q;
      end
      if (is_take) begin
        found_q     <= 1'b1;
        best_p_q    <= rd_data_q.prio;
        best_t_q    <= rd_data_q.ts;
        best_idx_q  <= rd_idx_q;
        best_host_q <= rd_data_q.host;
        best_slot_q <= rd_data_q.slot;
      end
    end
    if (emit) begin
      out_kind_q <= emit_kind;
      out_had_q  <= emit_had;
      out_host_q <= '0;
      out_slot_q <= emit_slot;
      out_last_q <= emit_last;
    end else if (cmd_i.emit_give) begin
      out_kind_q <= KIND_GIVE;
      out_had_q  <= 1'b0;
      out_host_q <= best_host_q;
      out_slot_q <= best_slot_q;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_had_o   = out_had_q;
  assign out_host_o  = out_host_q;
  assign out_slot_o  = out_slot_q;
  assign out_last_o  = out_last_q;

`ifndef ASSERT_OFF
  a_commit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit || cmd_i.emit_give) |-> !out_valid_q)
    else $error("result written over a pending beat");
  a_read_follows_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(cmd_i.scan_rd))
    else $error("read data flagged without a read");
  a_give_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_give |=> out_valid_q && (out_kind_q == KIND_GIVE) && out_last_q)
    else $error("give beat not presented");
  a_give_holder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_give |-> holder_valid_q && (holder_idx_q == best_idx_q))
    else $error("give without new holder");
`endif

endmodule
